[sv/assert_macros.svh]
// Assertion macros shared by the RTL. Each one samples on i_clk and is
// disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, expr, msg)

`define ASSERT_IMPLIES(lbl, ante, cons, msg)

`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[sv/ttint_pkg.sv]
package ttint_pkg;

    localparam int DEF_TABLE_DEPTH = 256;
    localparam int DEF_VALUE_BITS  = 32;
    localparam int DEF_FRAC_BITS   = 16;

    localparam int FIELD_W    = 32;
    localparam int TIME_W     = 32;
    localparam int NUM_VALUES = 9;
    localparam int KW         = $clog2(NUM_VALUES);

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_ORDER = 2'd3
    } t_status;

    typedef struct packed {
        t_op                                   op;
        logic [TIME_W-1:0]                     time_us;
        logic [NUM_VALUES-1:0][FIELD_W-1:0]    values;
    } t_in_item;

    typedef struct packed {
        t_status                               status;
        logic [NUM_VALUES-1:0][FIELD_W-1:0]    values;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic srd;
        logic scmp;
        logic set_lr;
        logic tl_rd;
        logic tr_rd;
        logic den;
        logic div;
        logic vl_rd;
        logic vr_rd;
        logic bmul;
        logic badd;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic query_go;
        logic search_done;
        logic lr_equal;
        logic div_last;
        logic blend_last;
        logic out_free;
    } t_sts;

endpackage

[sv/ttint_in_if.sv]
interface ttint_in_if;
    import ttint_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [1:0]                operation;
    logic [TIME_W-1:0]         time_us;
    logic signed [FIELD_W-1:0] pos_x_in;
    logic signed [FIELD_W-1:0] pos_y_in;
    logic signed [FIELD_W-1:0] pos_z_in;
    logic signed [FIELD_W-1:0] vel_x_in;
    logic signed [FIELD_W-1:0] vel_y_in;
    logic signed [FIELD_W-1:0] vel_z_in;
    logic signed [FIELD_W-1:0] acc_x_in;
    logic signed [FIELD_W-1:0] acc_y_in;
    logic signed [FIELD_W-1:0] acc_z_in;

    modport source (
        output valid, operation, time_us, pos_x_in, pos_y_in, pos_z_in,
               vel_x_in, vel_y_in, vel_z_in, acc_x_in, acc_y_in, acc_z_in,
        input  ready
    );

    modport sink (
        input  valid, operation, time_us, pos_x_in, pos_y_in, pos_z_in,
               vel_x_in, vel_y_in, vel_z_in, acc_x_in, acc_y_in, acc_z_in,
        output ready
    );

endinterface

[sv/ttint_out_if.sv]
interface ttint_out_if;
    import ttint_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [1:0]                status;
    logic signed [FIELD_W-1:0] pos_x_out;
    logic signed [FIELD_W-1:0] pos_y_out;
    logic signed [FIELD_W-1:0] pos_z_out;
    logic signed [FIELD_W-1:0] vel_x_out;
    logic signed [FIELD_W-1:0] vel_y_out;
    logic signed [FIELD_W-1:0] vel_z_out;
    logic signed [FIELD_W-1:0] acc_x_out;
    logic signed [FIELD_W-1:0] acc_y_out;
    logic signed [FIELD_W-1:0] acc_z_out;

    modport source (
        output valid, status, pos_x_out, pos_y_out, pos_z_out,
               vel_x_out, vel_y_out, vel_z_out, acc_x_out, acc_y_out, acc_z_out,
        input  ready
    );

    modport sink (
        input  valid, status, pos_x_out, pos_y_out, pos_z_out,
               vel_x_out, vel_y_out, vel_z_out, acc_x_out, acc_y_out, acc_z_out,
        output ready
    );

endinterface

[sv/ttint_ctrl.sv]
module ttint_ctrl
    import ttint_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_SRD  = 12'b0000_0000_0010,
        S_SCMP = 12'b0000_0000_0100,
        S_TL   = 12'b0000_0000_1000,
        S_TR   = 12'b0000_0001_0000,
        S_DEN  = 12'b0000_0010_0000,
        S_DIV  = 12'b0000_0100_0000,
        S_VL   = 12'b0000_1000_0000,
        S_VR   = 12'b0001_0000_0000,
        S_BMUL = 12'b0010_0000_0000,
        S_BADD = 12'b0100_0000_0000,
        S_DONE = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_sts.query_go ? S_SRD : S_DONE;
                end
            end
            S_SRD: begin
                if (i_sts.search_done) begin
                    o_cmd.set_lr = 1'b1;
                    n_state      = S_TL;
                end else begin
                    o_cmd.srd = 1'b1;
                    n_state   = S_SCMP;
                end
            end
            S_SCMP: begin
                o_cmd.scmp = 1'b1;
                n_state    = S_SRD;
            end
            S_TL: begin
                o_cmd.tl_rd = 1'b1;
                n_state     = S_TR;
            end
            S_TR: begin
                o_cmd.tr_rd = 1'b1;
                n_state     = S_DEN;
            end
            S_DEN: begin
                o_cmd.den = 1'b1;
                n_state   = i_sts.lr_equal ? S_VL : S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_state   = i_sts.div_last ? S_VL : S_DIV;
            end
            S_VL: begin
                o_cmd.vl_rd = 1'b1;
                n_state     = S_VR;
            end
            S_VR: begin
                o_cmd.vr_rd = 1'b1;
                n_state     = S_BMUL;
            end
            S_BMUL: begin
                o_cmd.bmul = 1'b1;
                n_state    = S_BADD;
            end
            S_BADD: begin
                o_cmd.badd = 1'b1;
                n_state    = i_sts.blend_last ? S_DONE : S_BMUL;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

[sv/ttint_dp.sv]
module ttint_dp
    import ttint_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int VALUE_BITS  = DEF_VALUE_BITS,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  t_cmd      i_cmd,
    input  logic      i_out_ready,
    output t_sts      o_sts,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int ROW_W   = NUM_VALUES * VALUE_BITS;
    localparam int ALPHA_W = FRAC_BITS + 1;
    localparam int PROD_W  = VALUE_BITS + ALPHA_W;
    localparam int DIVC_W  = $clog2(FRAC_BITS + 1);

    logic [TIME_W-1:0] tmem [TABLE_DEPTH];
    logic [ROW_W-1:0]  vmem [TABLE_DEPTH];

    logic [CNT_W-1:0]      r_count;
    logic [TIME_W-1:0]     r_first;
    logic [TIME_W-1:0]     r_last;
    logic [TIME_W-1:0]     r_q;
    t_status               r_status;
    logic                  r_qok;
    logic [TIME_W-1:0]     r_trd;
    logic [ROW_W-1:0]      r_vrd;
    logic [ROW_W-1:0]      r_vl;
    logic [CNT_W-1:0]      r_lo;
    logic [CNT_W-1:0]      r_hi;
    logic [IDX_W-1:0]      r_mid;
    logic [IDX_W-1:0]      r_left;
    logic [IDX_W-1:0]      r_right;
    logic [TIME_W-1:0]     r_tl;
    logic [TIME_W-1:0]     r_den;
    logic [TIME_W:0]       r_rem;
    logic [ALPHA_W-1:0]    r_alpha;
    logic [DIVC_W-1:0]     r_div_cnt;
    logic [KW-1:0]         r_k;
    logic [PROD_W-1:0]     r_prod;
    logic                  r_neg;
    logic [VALUE_BITS-1:0] r_lv;
    logic [VALUE_BITS-1:0] r_res [NUM_VALUES];
    logic                  r_out_valid;
    t_out_item             r_out;

    logic                  w_full;
    logic                  w_order;
    logic                  w_app_ok;
    logic [TIME_W-1:0]     w_qclamp;
    logic [ROW_W-1:0]      w_row_in;
    logic [CNT_W:0]        w_sum;
    logic [IDX_W-1:0]      w_mid;
    logic [IDX_W-1:0]      w_last;
    logic [IDX_W-1:0]      w_right;
    logic [IDX_W-1:0]      w_taddr;
    logic [IDX_W-1:0]      w_vaddr;
    logic                  w_ge;
    logic [TIME_W:0]       w_nrem;
    logic [VALUE_BITS-1:0] w_l;
    logic [VALUE_BITS-1:0] w_r;
    logic [VALUE_BITS:0]   w_d;
    logic [VALUE_BITS:0]   w_abs;
    logic [PROD_W-1:0]     w_rnd;
    logic [VALUE_BITS-1:0] w_sc;

    assign w_full   = (r_count == CNT_W'(TABLE_DEPTH));
    assign w_order  = (r_count != '0) && (i_item.time_us <= r_last);
    assign w_app_ok = !w_full && !w_order;

    always_comb begin
        if (i_item.time_us < r_first) begin
            w_qclamp = r_first;
        end else if (i_item.time_us > r_last) begin
            w_qclamp = r_last;
        end else begin
            w_qclamp = i_item.time_us;
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_VALUES; k++) begin
            w_row_in[k*VALUE_BITS +: VALUE_BITS] = VALUE_BITS'($signed(i_item.values[k]));
        end
    end

    assign w_sum   = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid   = w_sum[IDX_W:1];
    assign w_last  = IDX_W'(r_count - CNT_W'(1));
    assign w_right = (r_lo < r_count) ? r_lo[IDX_W-1:0] : w_last;

    assign w_taddr = i_cmd.tl_rd ? r_left : (i_cmd.tr_rd ? r_right : w_mid);
    assign w_vaddr = i_cmd.vl_rd ? r_left : r_right;

    assign w_ge   = (r_rem >= {1'b0, r_den});
    assign w_nrem = w_ge ? (r_rem - {1'b0, r_den}) : r_rem;

    assign w_l   = r_vl[r_k*VALUE_BITS +: VALUE_BITS];
    assign w_r   = r_vrd[r_k*VALUE_BITS +: VALUE_BITS];
    assign w_d   = {w_r[VALUE_BITS-1], w_r} - {w_l[VALUE_BITS-1], w_l};
    assign w_abs = w_d[VALUE_BITS] ? (~w_d + (VALUE_BITS+1)'(1)) : w_d;
    assign w_rnd = r_prod + (PROD_W'(1) << (FRAC_BITS - 1));
    assign w_sc  = VALUE_BITS'(w_rnd >> FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (i_item.op == OP_APPEND) && w_app_ok) begin
            tmem[r_count[IDX_W-1:0]] <= i_item.time_us;
            vmem[r_count[IDX_W-1:0]] <= w_row_in;
        end
        r_trd <= tmem[w_taddr];
        r_vrd <= vmem[w_vaddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.accept) begin
            if (i_item.op == OP_CLEAR) begin
                r_count <= '0;
            end else if ((i_item.op == OP_APPEND) && w_app_ok) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            unique case (i_item.op)
                OP_APPEND: begin
                    r_qok <= 1'b0;
                    if (w_full) begin
                        r_status <= ST_FULL;
                    end else if (w_order) begin
                        r_status <= ST_ORDER;
                    end else begin
                        r_status <= ST_OK;
                        r_last   <= i_item.time_us;
                        if (r_count == '0) begin
                            r_first <= i_item.time_us;
                        end
                    end
                end
                OP_QUERY: begin
                    if (r_count == '0) begin
                        r_status <= ST_EMPTY;
                        r_qok    <= 1'b0;
                    end else begin
                        r_status <= ST_OK;
                        r_qok    <= 1'b1;
                        r_q      <= w_qclamp;
                        r_lo     <= '0;
                        r_hi     <= r_count;
                    end
                end
                OP_CLEAR, OP_NONE: begin
                    r_status <= ST_OK;
                    r_qok    <= 1'b0;
                end
                default: begin
                    r_status <= ST_OK;
                    r_qok    <= 1'b0;
                end
            endcase
        end
        if (i_cmd.srd) begin
            r_mid <= w_mid;
        end
        if (i_cmd.scmp) begin
            if (r_trd <= r_q) begin
                r_lo <= CNT_W'(r_mid) + CNT_W'(1);
            end else begin
                r_hi <= CNT_W'(r_mid);
            end
        end
        if (i_cmd.set_lr) begin
            r_right <= w_right;
            r_left  <= (w_right == '0) ? '0 : (w_right - IDX_W'(1));
        end
        if (i_cmd.tr_rd) begin
            r_tl <= r_trd;
        end
        if (i_cmd.den) begin
            r_den     <= r_trd - r_tl;
            r_rem     <= {1'b0, r_q - r_tl};
            r_alpha   <= '0;
            r_div_cnt <= '0;
        end
        if (i_cmd.div) begin
            r_rem     <= {w_nrem[TIME_W-1:0], 1'b0};
            r_alpha   <= {r_alpha[ALPHA_W-2:0], w_ge};
            r_div_cnt <= r_div_cnt + DIVC_W'(1);
        end
        if (i_cmd.vr_rd) begin
            r_vl <= r_vrd;
            r_k  <= '0;
        end
        if (i_cmd.bmul) begin
            r_prod <= PROD_W'(w_abs[VALUE_BITS-1:0]) * PROD_W'(r_alpha);
            r_neg  <= w_d[VALUE_BITS];
            r_lv   <= w_l;
        end
        if (i_cmd.badd) begin
            r_res[r_k] <= r_neg ? (r_lv - w_sc) : (r_lv + w_sc);
            r_k        <= r_k + KW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.status <= r_status;
            for (int k = 0; k < NUM_VALUES; k++) begin
                r_out.values[k] <= r_qok ? FIELD_W'($signed(r_res[k])) : '0;
            end
        end
    end

    assign o_sts.query_go    = (i_item.op == OP_QUERY) && (r_count != '0);
    assign o_sts.search_done = !(r_lo < r_hi);
    assign o_sts.lr_equal    = (r_left == r_right);
    assign o_sts.div_last    = (r_div_cnt == DIVC_W'(FRAC_BITS));
    assign o_sts.blend_last  = (r_k == KW'(NUM_VALUES - 1));
    assign o_sts.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

[sv/trajectory_time_interpolator.sv]
// Trajectory sample table with time interpolation. Each input transaction
// clears the table, appends one sample (time and nine Q16.16 values), or
// queries a time; every transaction returns exactly one result transaction.
// Clear, append and ignored codes, and a query of an empty table, go straight
// to the result. A query otherwise runs a binary search whose probes each read
// the registered time memory (S_SRD) and then compare (S_SCMP); the blend
// fraction comes from a restoring divider that yields one quotient bit a
// cycle, and the nine values share one multiplier, each with a multiply step
// and an add step. One item is in flight at a time; the output register lets
// the next transaction enter while a result waits.
`include "assert_macros.svh"

module trajectory_time_interpolator
    import ttint_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int VALUE_BITS  = DEF_VALUE_BITS,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ttint_in_if.sink    i_in,
    ttint_out_if.source o_out
);

    t_in_item  w_item;
    t_out_item w_out_item;
    t_cmd      w_cmd;
    t_sts      w_sts;
    logic      w_in_ready;
    logic      w_out_valid;

    assign w_item.op        = t_op'(i_in.operation);
    assign w_item.time_us   = i_in.time_us;
    assign w_item.values[0] = i_in.pos_x_in;
    assign w_item.values[1] = i_in.pos_y_in;
    assign w_item.values[2] = i_in.pos_z_in;
    assign w_item.values[3] = i_in.vel_x_in;
    assign w_item.values[4] = i_in.vel_y_in;
    assign w_item.values[5] = i_in.vel_z_in;
    assign w_item.values[6] = i_in.acc_x_in;
    assign w_item.values[7] = i_in.acc_y_in;
    assign w_item.values[8] = i_in.acc_z_in;

    ttint_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    ttint_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_BITS  (VALUE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (w_item),
        .i_cmd       (w_cmd),
        .i_out_ready (o_out.ready),
        .o_sts       (w_sts),
        .o_out_valid (w_out_valid),
        .o_out_item  (w_out_item)
    );

    assign i_in.ready      = w_in_ready;
    assign o_out.valid     = w_out_valid;
    assign o_out.status    = w_out_item.status;
    assign o_out.pos_x_out = w_out_item.values[0];
    assign o_out.pos_y_out = w_out_item.values[1];
    assign o_out.pos_z_out = w_out_item.values[2];
    assign o_out.vel_x_out = w_out_item.values[3];
    assign o_out.vel_y_out = w_out_item.values[4];
    assign o_out.vel_z_out = w_out_item.values[5];
    assign o_out.acc_x_out = w_out_item.values[6];
    assign o_out.acc_y_out = w_out_item.values[7];
    assign o_out.acc_z_out = w_out_item.values[8];

    `ASSERT_ALWAYS(a_cmd_excl, $onehot0(w_cmd), "controller issued two commands at once")
    `ASSERT_IMPLIES(a_out_src, $rose(o_out.valid), $past(w_cmd.out_load), "result without load")
    `ASSERT_NEXT(a_one_item, w_cmd.accept, !w_in_ready, "second transaction taken while busy")

endmodule
